// ----- hdl/scfr_pkg.sv -----
`default_nettype none
package scfr_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 7;
	localparam int IDX_W    = 6;
	localparam int CRC_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;

	typedef struct packed {
		logic crc_init;
		logic crc_upd;
		logic cap_cmd;
		logic cap_seq;
		logic cap_len;
		logic clr_wpos;
		logic wr_pay;
		logic cap_crc_hi;
		logic rd_clr;
		logic rd_next;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic match_first;
		logic match_second;
		logic len_big;
		logic len_zero_in;
		logic wpos_done;
		logic crc_match;
		logic held_len_zero;
		logic rd_last;
		logic out_free;
	} dp_status_t;

	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] acc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = acc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != '0) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/scfr_if.sv -----
`default_nettype none
interface scfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfr_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_command;
	logic [7:0] frame_sequence;
	logic [6:0] frame_length;
	logic       has_payload;
	logic [7:0] payload_byte;
	logic [5:0] byte_index;
	logic       last;

	modport source (output valid, output frame_command, output frame_sequence,
		output frame_length, output has_payload, output payload_byte,
		output byte_index, output last, input ready);
	modport sink (input valid, input frame_command, input frame_sequence,
		input frame_length, input has_payload, input payload_byte,
		input byte_index, input last, output ready);
endinterface
`default_nettype wire

// ----- hdl/scfr_ctrl.sv -----
`default_nettype none
module scfr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     ready,
	input  wire scfr_pkg::dp_status_t status,
	output scfr_pkg::ctrl_cmd_t      cmd
);
	import scfr_pkg::*;

	localparam logic [3:0] ST_SYNC0   = 4'd0;
	localparam logic [3:0] ST_SYNC1   = 4'd1;
	localparam logic [3:0] ST_CMD     = 4'd2;
	localparam logic [3:0] ST_SEQ     = 4'd3;
	localparam logic [3:0] ST_LEN     = 4'd4;
	localparam logic [3:0] ST_PAYLOAD = 4'd5;
	localparam logic [3:0] ST_CRC_HI  = 4'd6;
	localparam logic [3:0] ST_CRC_LO  = 4'd7;
	localparam logic [3:0] ST_EMIT_RD = 4'd8;
	localparam logic [3:0] ST_EMIT_LD = 4'd9;

	logic [3:0] st_q;
	logic [3:0] st_d;
	logic       in_fire;

	assign ready   = (st_q != ST_EMIT_RD) && (st_q != ST_EMIT_LD);
	assign in_fire = in_valid && ready;

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		case (st_q)
			ST_SYNC1: begin
				if (in_fire) begin
					if (status.match_second) begin
						st_d         = ST_CMD;
						cmd.crc_init = 1'b1;
					end else begin
						st_d = ST_SYNC0;
					end
				end
			end
			ST_CMD: begin
				if (in_fire) begin
					cmd.cap_cmd = 1'b1;
					cmd.crc_upd = 1'b1;
					st_d        = ST_SEQ;
				end
			end
			ST_SEQ: begin
				if (in_fire) begin
					cmd.cap_seq = 1'b1;
					cmd.crc_upd = 1'b1;
					st_d        = ST_LEN;
				end
			end
			ST_LEN: begin
				if (in_fire) begin
					cmd.cap_len = 1'b1;
					cmd.crc_upd = 1'b1;
					if (status.len_big) begin
						st_d = ST_SYNC0;
					end else if (status.len_zero_in) begin
						st_d = ST_CRC_HI;
					end else begin
						cmd.clr_wpos = 1'b1;
						st_d         = ST_PAYLOAD;
					end
				end
			end
			ST_PAYLOAD: begin
				if (in_fire) begin
					cmd.wr_pay  = 1'b1;
					cmd.crc_upd = 1'b1;
					if (status.wpos_done) begin
						st_d = ST_CRC_HI;
					end
				end
			end
			ST_CRC_HI: begin
				if (in_fire) begin
					cmd.cap_crc_hi = 1'b1;
					st_d           = ST_CRC_LO;
				end
			end
			ST_CRC_LO: begin
				if (in_fire) begin
					if (status.crc_match) begin
						cmd.rd_clr = 1'b1;
						st_d = status.held_len_zero ? ST_EMIT_LD : ST_EMIT_RD;
					end else begin
						st_d = ST_SYNC0;
					end
				end
			end
			ST_EMIT_RD: begin
				st_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (status.held_len_zero || status.rd_last) begin
						st_d = ST_SYNC0;
					end else begin
						cmd.rd_next = 1'b1;
						st_d        = ST_EMIT_RD;
					end
				end
			end
			default: begin
				if (in_fire) begin
					st_d = status.match_first ? ST_SYNC1 : ST_SYNC0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_SYNC0;
		end else begin
			st_q <= st_d;
		end
	end

`ifndef SYNTHESIS
	a_payload_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PAYLOAD && in_fire && status.wpos_done) |=> (st_q == ST_CRC_HI))
		else $error("payload end did not move to crc capture");
	a_crc_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CRC_LO && in_fire && !status.crc_match) |=> (st_q == ST_SYNC0))
		else $error("crc mismatch did not drop the frame");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT_LD && !status.out_free) |=> (st_q == ST_EMIT_LD))
		else $error("emission advanced over a held beat");
`endif

endmodule
`default_nettype wire

// ----- hdl/scfr_dp.sv -----
`default_nettype none
module scfr_dp #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [scfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [scfr_pkg::BYTE_W-1:0]  cfg_wdata,
	input  wire logic [scfr_pkg::BYTE_W-1:0]  rx_byte,
	input  wire scfr_pkg::ctrl_cmd_t          cmd,
	output scfr_pkg::dp_status_t              status,
	scfr_frame_if.source                      frame
);
	import scfr_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic [BYTE_W-1:0] held_cmd_q;
	logic [BYTE_W-1:0] held_seq_q;
	logic [LEN_W-1:0]  held_len_q;
	logic [LEN_W-1:0]  wpos_q;
	logic [LEN_W-1:0]  wpos_inc;
	logic [CRC_W-1:0]  crc_q;
	logic [BYTE_W-1:0] rcrc_hi_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
	logic              out_valid_q;
	logic              out_free;
	logic              last_out;

	assign wpos_inc = wpos_q + LEN_W'(1);
	assign out_free = !out_valid_q || frame.ready;
	assign last_out = status.held_len_zero || status.rd_last;

	always_comb begin
		status.match_first   = (rx_byte == sync_first_q);
		status.match_second  = (rx_byte == sync_second_q);
		status.len_big       = (rx_byte > BYTE_W'(MAX_PAYLOAD));
		status.len_zero_in   = (rx_byte == '0);
		status.wpos_done     = (wpos_inc >= held_len_q);
		status.crc_match     = (crc_q == {rcrc_hi_q, rx_byte});
		status.held_len_zero = (held_len_q == '0);
		status.rd_last       = ((LEN_W'(rd_idx_q) + LEN_W'(1)) == held_len_q);
		status.out_free      = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata;
				CFG_SYNC_SECOND: sync_second_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_cmd) begin
			held_cmd_q <= rx_byte;
		end
		if (cmd.cap_seq) begin
			held_seq_q <= rx_byte;
		end
		if (cmd.cap_len) begin
			held_len_q <= rx_byte[LEN_W-1:0];
		end
		if (cmd.clr_wpos) begin
			wpos_q <= '0;
		end else if (cmd.wr_pay) begin
			wpos_q <= wpos_inc;
		end
		if (cmd.crc_init) begin
			crc_q <= CRC_INIT;
		end else if (cmd.crc_upd) begin
			crc_q <= crc16_byte(crc_q, rx_byte);
		end
		if (cmd.cap_crc_hi) begin
			rcrc_hi_q <= rx_byte;
		end
		if (cmd.rd_clr) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_next) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_pay) begin
			mem[wpos_q[AW-1:0]] <= rx_byte;
		end
		rd_data_q <= mem[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			frame.frame_command  <= held_cmd_q;
			frame.frame_sequence <= held_seq_q;
			frame.frame_length   <= held_len_q;
			frame.has_payload    <= !status.held_len_zero;
			frame.payload_byte   <= status.held_len_zero ? '0 : rd_data_q;
			frame.byte_index     <= status.held_len_zero ? '0 : rd_idx_q;
			frame.last           <= last_out;
		end
	end

	assign frame.valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output beat overwritten before it was taken");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !status.held_len_zero) |-> (LEN_W'(rd_idx_q) < held_len_q))
		else $error("payload read beyond frame length");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (frame.valid && (frame.last == $past(last_out))))
		else $error("loaded beat not presented");
`endif

endmodule
`default_nettype wire

// ----- hdl/sync_crc_frame_receiver_top.sv -----
// Channel  Dir  Beat                                      Accepted when
// rx       in   rx_byte                                   rx.valid && rx.ready
// frame    out  command, sequence, length, payload byte   frame.valid && frame.ready
// cfg      in   cfg_index, cfg_wdata                      cfg_we
//
// Receiving, one rx beat is taken per cycle.
// After the low CRC byte of a matching frame rx stalls while the payload is read
// back: a memory read step and an output load step per frame beat, one load-only beat for an empty frame.
// The last frame beat may wait in the output register while rx is taken again.
// Reset is asynchronous; the payload memory has no clearing pass.
// frame.ready low while a beat is waiting holds the emission loop at its load step.
`default_nettype none
module sync_crc_frame_receiver_top #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [scfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [scfr_pkg::BYTE_W-1:0]    cfg_wdata,
	scfr_rx_if.sink                             rx,
	scfr_frame_if.source                        frame
);
	import scfr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       ctl_ready;

	assign rx.ready = ctl_ready;

	scfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.ready    (ctl_ready),
		.status   (status),
		.cmd      (cmd)
	);

	scfr_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.status    (status),
		.frame     (frame)
	);

endmodule
`default_nettype wire
